// ===== hw/rtl/hpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpc_pkg
// Shared types and constants of the hysteresis pump controller.
// ----------------------------------------------------------------------------
package hpc_pkg;

   localparam int PCT_W   = 7;
   localparam int EPOCH_W = 48;
   localparam int RTM_W   = 32;
   localparam int CMD_W   = 2;
   localparam int EV_W    = 2;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

   // command codes
   localparam logic [CMD_W-1:0] CMD_SAMPLE     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOTE_ON  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOTE_OFF = 2'd2;

   // event codes
   localparam logic [EV_W-1:0] EV_NONE         = 2'd0;
   localparam logic [EV_W-1:0] EV_AUTO_START   = 2'd1;
   localparam logic [EV_W-1:0] EV_REMOTE_START = 2'd2;
   localparam logic [EV_W-1:0] EV_STOP         = 2'd3;

   // register indexes
   localparam logic [CSR_AW-1:0] REG_ON_THRESHOLD  = 3'd0;
   localparam logic [CSR_AW-1:0] REG_OFF_THRESHOLD = 3'd1;
   localparam logic [CSR_AW-1:0] REG_MAX_RUNTIME   = 3'd2;
   localparam logic [CSR_AW-1:0] REG_SENSOR_MIN    = 3'd3;
   localparam logic [CSR_AW-1:0] REG_SENSOR_MAX    = 3'd4;
   localparam logic [CSR_AW-1:0] REG_DRY_POINT     = 3'd5;
   localparam logic [CSR_AW-1:0] REG_WET_POINT     = 3'd6;

   // register reset values
   localparam logic [PCT_W-1:0] RST_ON_THRESHOLD  = 7'd30;
   localparam logic [PCT_W-1:0] RST_OFF_THRESHOLD = 7'd70;
   localparam logic [RTM_W-1:0] RST_MAX_RUNTIME   = 32'd60000;
   localparam int               RST_SENSOR_MIN    = 200;
   localparam int               RST_SENSOR_MAX    = 4095;
   localparam int               RST_DRY_POINT     = 4095;
   localparam int               RST_WET_POINT     = 1612;

endpackage
`default_nettype wire

// ===== hw/rtl/hpc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpc channel interfaces
// Valid/ready channels for commands, results and register writes.
// ----------------------------------------------------------------------------
interface hpc_req_if #(
   parameter int ADC_BITS  = 12,
   parameter int TIME_BITS = 32
);
   logic                           valid;
   logic                           ready;
   logic [hpc_pkg::CMD_W-1:0]      command;
   logic [ADC_BITS-1:0]            adc_value;
   logic [TIME_BITS-1:0]           time_ms;
   logic [hpc_pkg::EPOCH_W-1:0]    epoch_ms;

   modport source (output valid, command, adc_value, time_ms, epoch_ms, input ready);
   modport sink   (input valid, command, adc_value, time_ms, epoch_ms, output ready);
endinterface

interface hpc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           relay_level;
   logic                           pump_running;
   logic                           sensor_fault;
   logic [hpc_pkg::PCT_W-1:0]      moisture_pct;
   logic [hpc_pkg::EV_W-1:0]       event_kind;
   logic [hpc_pkg::PCT_W-1:0]      event_pct;
   logic [hpc_pkg::RTM_W-1:0]      run_duration_ms;
   logic [hpc_pkg::EPOCH_W-1:0]    start_epoch_out;

   modport source (output valid, relay_level, pump_running, sensor_fault, moisture_pct,
                   event_kind, event_pct, run_duration_ms, start_epoch_out, input ready);
   modport sink   (input valid, relay_level, pump_running, sensor_fault, moisture_pct,
                   event_kind, event_pct, run_duration_ms, start_epoch_out, output ready);
endinterface

interface hpc_csr_if;
   logic                           valid;
   logic                           ready;
   logic [hpc_pkg::CSR_AW-1:0]     index;
   logic [hpc_pkg::CSR_DW-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/hysteresis_pump_controller_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hysteresis_pump_controller_core
// Moisture-driven pump control with hysteresis, runtime limit and remote override.
// ----------------------------------------------------------------------------
// A moisture sample word goes from acceptance to its result word through latching,
// forming the scaled numerator and the calibration span, an overflow check and
// seven restoring-division steps on a single shared subtract/compare unit
// (one quotient bit per cycle), and a decision that waits for a free result
// register. Remote on/off words skip the divider and go straight to the decision.
// The block takes one word at a time; req_bus.ready is high only while it is idle,
// and a finished result waits in the output register while the next word is taken in.
// Register writes are always accepted and are meant for idle periods only.
module hysteresis_pump_controller_core #(
   parameter int ADC_BITS  = 12,
   parameter int TIME_BITS = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   hpc_req_if.sink    req_bus,
   hpc_rsp_if.source  rsp_bus,
   hpc_csr_if.sink    csr_bus
);

   localparam int NUM_W = ADC_BITS + hpc_pkg::PCT_W;
   localparam int QW    = hpc_pkg::PCT_W;
   localparam int SW    = $clog2(QW);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_CHECK,
      ST_STEP,
      ST_DECIDE
   } state_type;

   // configuration registers
   logic [hpc_pkg::PCT_W-1:0]   on_thr_ff;
   logic [hpc_pkg::PCT_W-1:0]   off_thr_ff;
   logic [hpc_pkg::RTM_W-1:0]   max_rt_ff;
   logic [ADC_BITS-1:0]         smin_ff;
   logic [ADC_BITS-1:0]         smax_ff;
   logic [ADC_BITS-1:0]         dry_ff;
   logic [ADC_BITS-1:0]         wet_ff;

   // latched command word
   logic [hpc_pkg::CMD_W-1:0]   cmd_ff;
   logic [ADC_BITS-1:0]         adc_ff;
   logic [TIME_BITS-1:0]        now_ff;
   logic [hpc_pkg::EPOCH_W-1:0] epoch_ff;

   // divider
   state_type                   state_ff;
   logic [NUM_W-1:0]            rem_ff;
   logic [NUM_W-1:0]            dsor_ff;
   logic [QW-1:0]               quo_ff;
   logic [SW-1:0]               step_ff;
   logic                        ovf_ff;
   logic                        neg_ff;
   logic                        span_zero_ff;

   // controller state
   logic                        pump_ff;
   logic                        fault_ff;
   logic [TIME_BITS-1:0]        start_ms_ff;
   logic [hpc_pkg::EPOCH_W-1:0] start_ep_ff;
   logic [hpc_pkg::PCT_W-1:0]   last_pct_ff;

   // result register
   logic                        rsp_valid_ff;
   logic                        rsp_pump_ff;
   logic                        rsp_fault_ff;
   logic [hpc_pkg::PCT_W-1:0]   rsp_pct_ff;
   logic [hpc_pkg::EV_W-1:0]    rsp_ev_ff;
   logic [hpc_pkg::PCT_W-1:0]   rsp_ev_pct_ff;
   logic [hpc_pkg::RTM_W-1:0]   rsp_dur_ff;
   logic [hpc_pkg::EPOCH_W-1:0] rsp_ep_ff;

   // ---------------------------------------------------------------- config
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         on_thr_ff  <= hpc_pkg::RST_ON_THRESHOLD;
         off_thr_ff <= hpc_pkg::RST_OFF_THRESHOLD;
         max_rt_ff  <= hpc_pkg::RST_MAX_RUNTIME;
         smin_ff    <= ADC_BITS'(hpc_pkg::RST_SENSOR_MIN);
         smax_ff    <= ADC_BITS'(hpc_pkg::RST_SENSOR_MAX);
         dry_ff     <= ADC_BITS'(hpc_pkg::RST_DRY_POINT);
         wet_ff     <= ADC_BITS'(hpc_pkg::RST_WET_POINT);
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            hpc_pkg::REG_ON_THRESHOLD:  on_thr_ff  <= csr_bus.data[hpc_pkg::PCT_W-1:0];
            hpc_pkg::REG_OFF_THRESHOLD: off_thr_ff <= csr_bus.data[hpc_pkg::PCT_W-1:0];
            hpc_pkg::REG_MAX_RUNTIME:   max_rt_ff  <= csr_bus.data;
            hpc_pkg::REG_SENSOR_MIN:    smin_ff    <= csr_bus.data[ADC_BITS-1:0];
            hpc_pkg::REG_SENSOR_MAX:    smax_ff    <= csr_bus.data[ADC_BITS-1:0];
            hpc_pkg::REG_DRY_POINT:     dry_ff     <= csr_bus.data[ADC_BITS-1:0];
            hpc_pkg::REG_WET_POINT:     wet_ff     <= csr_bus.data[ADC_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------- numerator/span
   logic [ADC_BITS:0]   diff_s;
   logic [ADC_BITS:0]   span_s;
   logic [ADC_BITS-1:0] diff_abs;
   logic [ADC_BITS-1:0] span_abs;
   logic [NUM_W-1:0]    diff_ext;
   logic [NUM_W-1:0]    num_abs;

   always_comb begin
      diff_s   = {1'b0, dry_ff} - {1'b0, adc_ff};
      span_s   = {1'b0, dry_ff} - {1'b0, wet_ff};
      diff_abs = diff_s[ADC_BITS] ? ADC_BITS'(-diff_s) : diff_s[ADC_BITS-1:0];
      span_abs = span_s[ADC_BITS] ? ADC_BITS'(-span_s) : span_s[ADC_BITS-1:0];
      diff_ext = NUM_W'(diff_abs);
      // times 100 as 64 + 32 + 4
      num_abs  = (diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2);
   end

   // shared subtract/compare unit
   logic [NUM_W:0] sub_w;
   logic           sub_ge;

   assign sub_w  = {1'b0, rem_ff} - {1'b0, dsor_ff};
   assign sub_ge = ~sub_w[NUM_W];

   // ------------------------------------------------------------- decision
   logic [hpc_pkg::PCT_W-1:0]   pct_w;
   logic [TIME_BITS-1:0]        elapsed_w;
   logic                        fault_in_w;
   logic                        want_w;
   logic                        pump_in;
   logic                        fault_in;
   logic [TIME_BITS-1:0]        start_ms_in;
   logic [hpc_pkg::EPOCH_W-1:0] start_ep_in;
   logic [hpc_pkg::PCT_W-1:0]   last_pct_in;
   logic [hpc_pkg::EV_W-1:0]    ev_in;
   logic [hpc_pkg::PCT_W-1:0]   ev_pct_in;
   logic [hpc_pkg::RTM_W-1:0]   dur_in;
   logic [hpc_pkg::EPOCH_W-1:0] ev_ep_in;

   always_comb begin
      priority if (span_zero_ff)
         pct_w = (adc_ff < dry_ff) ? hpc_pkg::PCT_FULL : '0;
      else if (neg_ff)
         pct_w = '0;
      else if (ovf_ff || quo_ff > hpc_pkg::PCT_FULL)
         pct_w = hpc_pkg::PCT_FULL;
      else
         pct_w = quo_ff;

      elapsed_w   = now_ff - start_ms_ff;
      fault_in_w  = (adc_ff < smin_ff) || (adc_ff > smax_ff);
      want_w      = pump_ff;

      pump_in     = pump_ff;
      fault_in    = fault_ff;
      start_ms_in = start_ms_ff;
      start_ep_in = start_ep_ff;
      last_pct_in = last_pct_ff;
      ev_in       = hpc_pkg::EV_NONE;
      ev_pct_in   = '0;
      dur_in      = '0;
      ev_ep_in    = '0;

      unique case (cmd_ff)
         hpc_pkg::CMD_SAMPLE: begin
            last_pct_in = pct_w;
            if (fault_in_w) begin
               fault_in = 1'b1;
               if (pump_ff) begin
                  ev_in       = hpc_pkg::EV_STOP;
                  ev_pct_in   = pct_w;
                  dur_in      = hpc_pkg::RTM_W'(elapsed_w);
                  ev_ep_in    = start_ep_ff;
                  pump_in     = 1'b0;
                  start_ms_in = '0;
                  start_ep_in = '0;
               end
            end else begin
               fault_in = 1'b0;
               priority if (pct_w < on_thr_ff)
                  want_w = 1'b1;
               else if (pct_w >= off_thr_ff)
                  want_w = 1'b0;
               else
                  want_w = pump_ff;
               // runtime limit
               if (pump_ff && want_w && (hpc_pkg::RTM_W'(elapsed_w) > max_rt_ff))
                  want_w = 1'b0;
               if (want_w != pump_ff) begin
                  if (pump_ff) begin
                     if (start_ep_ff != '0) begin
                        ev_in     = hpc_pkg::EV_STOP;
                        ev_pct_in = pct_w;
                        dur_in    = hpc_pkg::RTM_W'(elapsed_w);
                        ev_ep_in  = start_ep_ff;
                     end
                     pump_in     = 1'b0;
                     start_ms_in = '0;
                     start_ep_in = '0;
                  end else begin
                     pump_in     = 1'b1;
                     start_ms_in = now_ff;
                     start_ep_in = epoch_ff;
                     ev_in       = hpc_pkg::EV_AUTO_START;
                     ev_pct_in   = pct_w;
                     ev_ep_in    = epoch_ff;
                  end
               end
            end
         end
         hpc_pkg::CMD_REMOTE_ON: begin
            pump_in     = 1'b1;
            start_ms_in = now_ff;
            start_ep_in = epoch_ff;
            ev_in       = hpc_pkg::EV_REMOTE_START;
            ev_pct_in   = last_pct_ff;
            ev_ep_in    = epoch_ff;
         end
         hpc_pkg::CMD_REMOTE_OFF: begin
            if (start_ep_ff != '0) begin
               ev_in     = hpc_pkg::EV_STOP;
               ev_pct_in = last_pct_ff;
               dur_in    = (start_ms_ff != '0) ? hpc_pkg::RTM_W'(elapsed_w) : '0;
               ev_ep_in  = start_ep_ff;
            end
            pump_in     = 1'b0;
            start_ms_in = '0;
            start_ep_in = '0;
         end
         default: ;
      endcase
   end

   // -------------------------------------------------------- sequencer
   logic rsp_free;

   assign rsp_free      = ~rsp_valid_ff | rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pump_ff      <= 1'b0;
         fault_ff     <= 1'b0;
         start_ms_ff  <= '0;
         start_ep_ff  <= '0;
         last_pct_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the decision state refills the result register itself
         if (rsp_valid_ff && rsp_bus.ready && state_ff != ST_DECIDE)
            rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_bus.valid) begin
                  cmd_ff   <= req_bus.command;
                  adc_ff   <= req_bus.adc_value;
                  now_ff   <= req_bus.time_ms;
                  epoch_ff <= req_bus.epoch_ms;
                  state_ff <= (req_bus.command == hpc_pkg::CMD_SAMPLE) ? ST_LOAD : ST_DECIDE;
               end
            end
            ST_LOAD: begin
               rem_ff       <= num_abs;
               dsor_ff      <= {span_abs, QW'(0)};
               neg_ff       <= diff_s[ADC_BITS] ^ span_s[ADC_BITS];
               span_zero_ff <= (span_s == '0);
               state_ff     <= ST_CHECK;
            end
            ST_CHECK: begin
               // quotient beyond seven bits saturates
               ovf_ff   <= sub_ge;
               quo_ff   <= '0;
               dsor_ff  <= dsor_ff >> 1;
               step_ff  <= SW'(QW - 1);
               state_ff <= ST_STEP;
            end
            ST_STEP: begin
               if (sub_ge)
                  rem_ff <= sub_w[NUM_W-1:0];
               quo_ff  <= {quo_ff[QW-2:0], sub_ge};
               dsor_ff <= dsor_ff >> 1;
               step_ff <= step_ff - 1'b1;
               if (step_ff == '0)
                  state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               if (rsp_free) begin
                  pump_ff       <= pump_in;
                  fault_ff      <= fault_in;
                  start_ms_ff   <= start_ms_in;
                  start_ep_ff   <= start_ep_in;
                  last_pct_ff   <= last_pct_in;
                  rsp_valid_ff  <= 1'b1;
                  rsp_pump_ff   <= pump_in;
                  rsp_fault_ff  <= fault_in;
                  rsp_pct_ff    <= last_pct_in;
                  rsp_ev_ff     <= ev_in;
                  rsp_ev_pct_ff <= ev_pct_in;
                  rsp_dur_ff    <= dur_in;
                  rsp_ep_ff     <= ev_ep_in;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.relay_level     = ~rsp_pump_ff;
   assign rsp_bus.pump_running    = rsp_pump_ff;
   assign rsp_bus.sensor_fault    = rsp_fault_ff;
   assign rsp_bus.moisture_pct    = rsp_pct_ff;
   assign rsp_bus.event_kind      = rsp_ev_ff;
   assign rsp_bus.event_pct       = rsp_ev_pct_ff;
   assign rsp_bus.run_duration_ms = rsp_dur_ff;
   assign rsp_bus.start_epoch_out = rsp_ep_ff;

`ifndef ASSERT_OFF
   // a stopped pump keeps no run start
   a_idle_run_clear: assert property (@(posedge clock) disable iff (reset)
      !pump_ff |-> (start_ms_ff == '0 && start_ep_ff == '0))
      else $error("run start kept while pump stopped");

   // a stop event always leaves the pump off
   a_stop_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ev_ff == hpc_pkg::EV_STOP) |-> !rsp_pump_ff)
      else $error("stop event with pump running");

   // start events always leave the pump on
   a_start_on: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ev_ff == hpc_pkg::EV_AUTO_START ||
                        rsp_ev_ff == hpc_pkg::EV_REMOTE_START)) |-> rsp_pump_ff)
      else $error("start event with pump stopped");

   // percent stays clamped
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_pct_ff <= hpc_pkg::PCT_FULL && rsp_ev_pct_ff <= hpc_pkg::PCT_FULL))
      else $error("moisture percent out of range");

   // one word at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("ready right after accept");
`endif

endmodule
`default_nettype wire
